// File: rtl/msbp_pkg.sv
// ----------------------------------------------------------------------------
// msbp_pkg
// Types and constants shared by the MSB-first bit packer modules.
// ----------------------------------------------------------------------------
package msbp_pkg;

	localparam int BYTE_W     = 8;
	localparam int VALUE_W    = 32;
	localparam int COUNT_W    = 6;
	localparam int PART_W     = BYTE_W - 1;
	localparam int FILL_W     = 3;
	localparam int MAX_BYTES  = 4;
	localparam int NB_W       = 3;
	localparam int JOB_DEPTH  = 2;
	localparam int JOB_AW     = $clog2(JOB_DEPTH);
	localparam int JOB_CW     = $clog2(JOB_DEPTH + 1);
	localparam int IDX_W      = $clog2(MAX_BYTES);

	localparam logic [COUNT_W-1:0] MAX_APPEND = COUNT_W'(VALUE_W);

	typedef enum logic {
		REQ_APPEND = 1'b0,
		REQ_FLUSH  = 1'b1
	} req_type_t;

	typedef struct packed {
		logic                 req_type;
		logic [VALUE_W-1:0]   value;
		logic [COUNT_W-1:0]   bit_count;
		logic                 pad_bit;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last;
	} result_t;

	// bytes[MAX_BYTES-1] goes out first
	typedef struct packed {
		logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
		logic [NB_W-1:0]                  byte_cnt;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// File: rtl/msb_first_bit_packer.sv
// ----------------------------------------------------------------------------
// msb_first_bit_packer
// Packs variable-width values MSB first into a byte stream.
// ----------------------------------------------------------------------------
// An item is taken every cycle while full is low; items that complete no byte
// cost no back-end time. Completed bytes leave through the output register at
// one per cycle while pop keeps up; an item yields 0 to 4 bytes at the result
// side. A two-entry job queue lets the input run ahead of the output; the first
// byte of an item passes through the job queue and then the output register.
module msb_first_bit_packer import msbp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	logic      accept;
	logic      job_wr;
	logic      job_rd;
	job_t      job_in;
	job_t      job_head;
	q_status_t q_status;

	assign full   = q_status.full;
	assign accept = push && !full;

	msbp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.job_wr (job_wr),
		.job    (job_in)
	);

	msbp_job_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_wr),
		.wr_job (job_in),
		.rd     (job_rd),
		.head   (job_head),
		.status (q_status)
	);

	msbp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (job_head),
		.q_status (q_status),
		.job_rd   (job_rd),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		job_wr |-> !q_status.full)
		else $error("job written into full queue");

	a_no_read_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		job_rd |-> !q_status.empty)
		else $error("job read from empty queue");

	a_job_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		job_wr |-> (job_in.byte_cnt != '0 && job_in.byte_cnt <= NB_W'(MAX_BYTES)))
		else $error("job byte count out of range");

	a_beat_after_job: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_status.empty && empty) |=> !empty)
		else $error("waiting job not moved to output register");

endmodule

// File: rtl/msbp_front.sv
// ----------------------------------------------------------------------------
// msbp_front
// Accepts items, merges them with the partial byte and forms byte jobs.
// ----------------------------------------------------------------------------
module msbp_front import msbp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  accept,
	input  item_t item,
	output logic  job_wr,
	output job_t  job
);

	logic [PART_W-1:0]          partial_q;
	logic [FILL_W-1:0]          fill_q;
	logic [PART_W-1:0]          partial_d;
	logic [FILL_W-1:0]          fill_d;
	logic [COUNT_W-1:0]         n_bits;
	logic [VALUE_W-1:0]         value_al;
	logic [BYTE_W-1:0]          part_al;
	logic [BYTE_W-1:0]          pad_fill;
	logic [VALUE_W+BYTE_W-1:0]  merged;
	logic [VALUE_W+BYTE_W-1:0]  rest;
	logic [COUNT_W-1:0]         total;
	logic [BYTE_W-1:0]          rest_top;
	logic [3:0]                 rem_sh;

	always_comb begin
		n_bits   = (item.bit_count > MAX_APPEND) ? MAX_APPEND : item.bit_count;
		// new bits left-aligned, then placed right behind the partial byte
		value_al = item.value << (MAX_APPEND - n_bits);
		part_al  = {1'b0, partial_q} << (4'(BYTE_W) - {1'b0, fill_q});
		merged   = {part_al, {VALUE_W{1'b0}}} | ({value_al, {BYTE_W{1'b0}}} >> fill_q);
		total    = COUNT_W'(fill_q) + n_bits;
		rest     = merged << {total[COUNT_W-1:3], 3'b000};
		rest_top = rest[VALUE_W+BYTE_W-1 -: BYTE_W];
		rem_sh   = 4'(BYTE_W) - {1'b0, total[2:0]};
		pad_fill = item.pad_bit ? (8'hFF >> fill_q) : 8'h00;

		job       = '0;
		job_wr    = 1'b0;
		partial_d = partial_q;
		fill_d    = fill_q;
		unique case (req_type_t'(item.req_type))
			REQ_APPEND: begin
				job.bytes    = merged[VALUE_W+BYTE_W-1 -: VALUE_W];
				job.byte_cnt = NB_W'(total[COUNT_W-1:3]);
				job_wr       = accept && (total[COUNT_W-1:3] != '0);
				partial_d    = PART_W'(rest_top >> rem_sh);
				fill_d       = total[2:0];
			end
			REQ_FLUSH: begin
				job.bytes[MAX_BYTES-1] = part_al | pad_fill;
				job.byte_cnt           = NB_W'(1);
				job_wr                 = accept && (fill_q != '0);
				partial_d              = '0;
				fill_d                 = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			fill_q    <= '0;
		end else if (accept) begin
			partial_q <= partial_d;
			fill_q    <= fill_d;
		end
	end

endmodule

// File: rtl/msbp_job_fifo.sv
// ----------------------------------------------------------------------------
// msbp_job_fifo
// Short queue of byte jobs between the front and the back.
// ----------------------------------------------------------------------------
module msbp_job_fifo import msbp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr,
	input  job_t      wr_job,
	input  logic      rd,
	output job_t      head,
	output q_status_t status
);

	job_t              mem_q [JOB_DEPTH];
	logic [JOB_AW-1:0] wptr_q;
	logic [JOB_AW-1:0] rptr_q;
	logic [JOB_CW-1:0] count_q;

	assign head         = mem_q[rptr_q];
	assign status.full  = (count_q == JOB_CW'(JOB_DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr)
				wptr_q <= (wptr_q == JOB_AW'(JOB_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (rd)
				rptr_q <= (rptr_q == JOB_AW'(JOB_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			unique case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/msbp_back.sv
// ----------------------------------------------------------------------------
// msbp_back
// Sends out the bytes of each job, one per cycle while pop keeps up, through an output register.
// ----------------------------------------------------------------------------
module msbp_back import msbp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  job_t      head,
	input  q_status_t q_status,
	output logic      job_rd,
	input  logic      pop,
	output logic      empty,
	output result_t   result
);

	logic [IDX_W-1:0] idx_q;
	logic             valid_q;
	result_t          result_q;
	logic             load;
	logic             is_last;

	assign load    = !q_status.empty && (!valid_q || pop);
	assign is_last = ({1'b0, idx_q} == head.byte_cnt - 1'b1);
	assign job_rd  = load && is_last;
	assign empty   = !valid_q;
	assign result  = result_q;

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.out_byte <= head.bytes[IDX_W'(MAX_BYTES - 1) - idx_q];
			result_q.last     <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= is_last ? '0 : idx_q + 1'b1;
			if (load)
				valid_q <= 1'b1;
			else if (pop)
				valid_q <= 1'b0;
		end
	end

endmodule
